### rtl/odhp_pkg.sv
package odhp_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam int ID_W = 62;

	// result kinds
	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_STATUS  = 2'd2;

	// end-of-datagram status codes
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
	localparam logic [1:0] ST_TRUNCATED   = 2'd2;

	// object types
	localparam logic [ID_W-1:0] TYPE_PLAIN    = 62'h00;
	localparam logic [ID_W-1:0] TYPE_EXTENDED = 62'h01;

	localparam logic [5:0] VARINT_LOW_MASK = 6'h3F;

	// one request from the front to the back: up to two results
	typedef struct packed {
		logic            has_first;  // header or payload result
		logic            first_hdr;  // 1 header, 0 payload
		logic [7:0]      pay_byte;
		logic            has_status;
		logic [1:0]      status;
		logic [ID_W-1:0] alias_val;
		logic [ID_W-1:0] group_val;
		logic [ID_W-1:0] object_val;
		logic [7:0]      prio;
	} entry_t;

endpackage

### rtl/object_datagram_header_parser.sv
// Object datagram header parser.
// Input channel (in_valid / in_stall): one datagram byte per request, with
// end_of_datagram high on the final byte. Output channel (out_valid /
// out_stall): one result per request - a header (kind 0) once the type,
// track alias, group id, object id, priority and any extension list are
// consumed, a payload byte (kind 1) for every byte after that, and an
// end-of-datagram status (kind 2: ok, unsupported type, truncated) after
// each final byte. last marks the final result caused by one input byte.
// Timing: a byte is taken every cycle while the two-entry request queue
// between the byte parser and the result stage has room; its results pass
// through that queue and then the output register, and a status behind a
// header or payload result follows it as a separate result. The result
// stage sends one result per cycle while out_stall is low, so a final byte
// with two results holds it longer; with no gaps in the input that can fill
// the queue and raise in_stall. Otherwise the rate is one byte per cycle.
// Stall: while out_stall is high the output register holds; the queue
// fills and in_stall rises once it is full.
// Reset: the parser returns to expecting a type field, the queue empties
// and out_valid drops.
module object_datagram_header_parser #(
	parameter int QDEPTH = odhp_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 data_byte,
	input  logic                       end_of_datagram,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 kind,
	output logic [odhp_pkg::ID_W-1:0]  alias_num,
	output logic [odhp_pkg::ID_W-1:0]  group_num,
	output logic [odhp_pkg::ID_W-1:0]  object_num,
	output logic [7:0]                 priority_res,
	output logic [7:0]                 payload_byte,
	output logic [1:0]                 status,
	output logic                       last
);
	import odhp_pkg::*;

	entry_t q_in, q_head;
	logic   q_push, q_pop, q_empty, q_full;

	// front: varint decode and phase tracking
	odhp_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.valid           (in_valid),
		.stall           (in_stall),
		.data_byte       (data_byte),
		.end_of_datagram (end_of_datagram),
		.q_full          (q_full),
		.q_push          (q_push),
		.q_entry         (q_in)
	);

	// requests waiting for the result stage
	odhp_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.pop        (q_pop),
		.head       (q_head),
		.empty      (q_empty),
		.full       (q_full)
	);

	// back: serializes each request into one or two results
	odhp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.valid        (out_valid),
		.stall        (out_stall),
		.kind         (kind),
		.alias_num    (alias_num),
		.group_num    (group_num),
		.object_num   (object_num),
		.priority_res (priority_res),
		.payload_byte (payload_byte),
		.status       (status),
		.last         (last)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("request pushed into full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("request popped from empty queue");

	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_STATUS) |-> last)
		else $error("status result not marked last");

	a_ids_only_on_header: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != KIND_HEADER) |-> (alias_num == '0 && priority_res == '0))
		else $error("header fields set on non-header result");

endmodule

### rtl/odhp_front.sv
module odhp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid,
	output logic                 stall,
	input  logic [7:0]           data_byte,
	input  logic                 end_of_datagram,
	input  logic                 q_full,
	output logic                 q_push,
	output odhp_pkg::entry_t     q_entry
);
	import odhp_pkg::*;

	typedef enum logic [3:0] {
		PH_TYPE,
		PH_ALIAS,
		PH_GROUP,
		PH_OBJECT,
		PH_PRIO,
		PH_EXTCOUNT,
		PH_EXTKEY,
		PH_EXTLEN,
		PH_EXTVAL,
		PH_PAYLOAD,
		PH_DISCARD
	} phase_t;

	phase_t          phase_q, phase_n;
	logic [ID_W-1:0] vv_q, vv_n;
	logic [2:0]      left_q, left_n;
	logic            hx_q, hx_n;
	logic [ID_W-1:0] alias_q, alias_n;
	logic [ID_W-1:0] group_q, group_n;
	logic [ID_W-1:0] object_q, object_n;
	logic [7:0]      prio_q, prio_n;
	logic [ID_W-1:0] ext_q, ext_n;
	logic [ID_W-1:0] skip_q, skip_n;

	logic            accept;
	logic [ID_W-1:0] fv_val;
	logic [2:0]      fv_left;
	logic            fv_done;
	logic [ID_W-1:0] ext_dec;
	logic [ID_W-1:0] skip_dec;
	logic            emit_hdr;
	logic            emit_pay;
	logic [1:0]      st;

	assign stall  = q_full;
	assign accept = valid && !q_full;

	// varint byte step
	always_comb begin
		if (left_q == 3'd0) begin
			fv_val = {{(ID_W-6){1'b0}}, data_byte[5:0] & VARINT_LOW_MASK};
			case (data_byte[7:6])
				2'd0:    fv_left = 3'd0;
				2'd1:    fv_left = 3'd1;
				2'd2:    fv_left = 3'd3;
				default: fv_left = 3'd7;
			endcase
		end else begin
			fv_val  = {vv_q[ID_W-9:0], data_byte};
			fv_left = left_q - 3'd1;
		end
		fv_done = (fv_left == 3'd0);
	end

	assign ext_dec  = (ext_q != '0) ? ext_q - 1'b1 : ext_q;
	assign skip_dec = (skip_q != '0) ? skip_q - 1'b1 : skip_q;

	always_comb begin
		phase_n  = phase_q;
		vv_n     = vv_q;
		left_n   = left_q;
		hx_n     = hx_q;
		alias_n  = alias_q;
		group_n  = group_q;
		object_n = object_q;
		prio_n   = prio_q;
		ext_n    = ext_q;
		skip_n   = skip_q;
		emit_hdr = 1'b0;
		emit_pay = 1'b0;
		st       = ST_OK;

		case (phase_q)
			PH_TYPE: begin
				vv_n   = fv_val;
				left_n = fv_left;
				if (fv_done) begin
					if (fv_val == TYPE_PLAIN || fv_val == TYPE_EXTENDED) begin
						hx_n    = (fv_val == TYPE_EXTENDED);
						phase_n = PH_ALIAS;
					end else begin
						phase_n = PH_DISCARD;
					end
				end
			end
			PH_ALIAS: begin
				vv_n   = fv_val;
				left_n = fv_left;
				if (fv_done) begin
					alias_n = fv_val;
					phase_n = PH_GROUP;
				end
			end
			PH_GROUP: begin
				vv_n   = fv_val;
				left_n = fv_left;
				if (fv_done) begin
					group_n = fv_val;
					phase_n = PH_OBJECT;
				end
			end
			PH_OBJECT: begin
				vv_n   = fv_val;
				left_n = fv_left;
				if (fv_done) begin
					object_n = fv_val;
					phase_n  = PH_PRIO;
				end
			end
			PH_PRIO: begin
				prio_n = data_byte;
				if (hx_q) begin
					phase_n = PH_EXTCOUNT;
				end else begin
					phase_n  = PH_PAYLOAD;
					emit_hdr = 1'b1;
				end
			end
			PH_EXTCOUNT: begin
				vv_n   = fv_val;
				left_n = fv_left;
				if (fv_done) begin
					ext_n = fv_val;
					if (fv_val == '0) begin
						phase_n  = PH_PAYLOAD;
						emit_hdr = 1'b1;
					end else begin
						phase_n = PH_EXTKEY;
					end
				end
			end
			PH_EXTKEY: begin
				vv_n   = fv_val;
				left_n = fv_left;
				if (fv_done) begin
					phase_n = PH_EXTLEN;
				end
			end
			PH_EXTLEN: begin
				vv_n   = fv_val;
				left_n = fv_left;
				if (fv_done) begin
					skip_n = fv_val;
					if (fv_val == '0) begin
						// zero-length value: extension done now
						ext_n = ext_dec;
						if (ext_dec == '0) begin
							phase_n  = PH_PAYLOAD;
							emit_hdr = 1'b1;
						end else begin
							phase_n = PH_EXTKEY;
						end
					end else begin
						phase_n = PH_EXTVAL;
					end
				end
			end
			PH_EXTVAL: begin
				skip_n = skip_dec;
				if (skip_dec == '0) begin
					ext_n = ext_dec;
					if (ext_dec == '0) begin
						phase_n  = PH_PAYLOAD;
						emit_hdr = 1'b1;
					end else begin
						phase_n = PH_EXTKEY;
					end
				end
			end
			PH_PAYLOAD: begin
				emit_pay = 1'b1;
			end
			default: begin
				phase_n = PH_DISCARD;
			end
		endcase

		case (phase_n)
			PH_PAYLOAD: st = ST_OK;
			PH_DISCARD: st = ST_UNSUPPORTED;
			default:    st = ST_TRUNCATED;
		endcase

		if (end_of_datagram) begin
			phase_n = PH_TYPE;
			vv_n    = '0;
			left_n  = 3'd0;
			hx_n    = 1'b0;
			ext_n   = '0;
			skip_n  = '0;
		end
	end

	always_comb begin
		q_entry.has_first  = emit_hdr || emit_pay;
		q_entry.first_hdr  = emit_hdr;
		q_entry.pay_byte   = data_byte;
		q_entry.has_status = end_of_datagram;
		q_entry.status     = st;
		q_entry.alias_val  = alias_n;
		q_entry.group_val  = group_n;
		q_entry.object_val = object_n;
		q_entry.prio       = prio_n;
	end

	assign q_push = accept && (emit_hdr || emit_pay || end_of_datagram);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TYPE;
			vv_q     <= '0;
			left_q   <= 3'd0;
			hx_q     <= 1'b0;
			alias_q  <= '0;
			group_q  <= '0;
			object_q <= '0;
			prio_q   <= '0;
			ext_q    <= '0;
			skip_q   <= '0;
		end else if (accept) begin
			phase_q  <= phase_n;
			vv_q     <= vv_n;
			left_q   <= left_n;
			hx_q     <= hx_n;
			alias_q  <= alias_n;
			group_q  <= group_n;
			object_q <= object_n;
			prio_q   <= prio_n;
			ext_q    <= ext_n;
			skip_q   <= skip_n;
		end
	end

endmodule

### rtl/odhp_queue.sv
module odhp_queue #(
	parameter int DEPTH = odhp_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  odhp_pkg::entry_t push_entry,
	input  logic             pop,
	output odhp_pkg::entry_t head,
	output logic             empty,
	output logic             full
);
	import odhp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/odhp_back.sv
module odhp_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  odhp_pkg::entry_t           head,
	input  logic                       q_empty,
	output logic                       q_pop,
	output logic                       valid,
	input  logic                       stall,
	output logic [1:0]                 kind,
	output logic [odhp_pkg::ID_W-1:0]  alias_num,
	output logic [odhp_pkg::ID_W-1:0]  group_num,
	output logic [odhp_pkg::ID_W-1:0]  object_num,
	output logic [7:0]                 priority_res,
	output logic [7:0]                 payload_byte,
	output logic [1:0]                 status,
	output logic                       last
);
	import odhp_pkg::*;

	logic valid_q;
	logic second_q;   // first result of head already sent
	logic load;
	logic send_first;
	logic send_hdr;
	logic send_pay;

	assign load       = (!valid_q || !stall) && !q_empty;
	assign send_first = head.has_first && !second_q;
	assign send_hdr   = send_first && head.first_hdr;
	assign send_pay   = send_first && !head.first_hdr;
	assign q_pop      = load && !(send_first && head.has_status);
	assign valid      = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q  <= 1'b1;
				second_q <= send_first && head.has_status;
			end else if (!stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind         <= send_hdr ? KIND_HEADER : (send_pay ? KIND_PAYLOAD : KIND_STATUS);
			alias_num    <= send_hdr ? head.alias_val : '0;
			group_num    <= send_hdr ? head.group_val : '0;
			object_num   <= send_hdr ? head.object_val : '0;
			priority_res <= send_hdr ? head.prio : 8'h00;
			payload_byte <= send_pay ? head.pay_byte : 8'h00;
			status       <= send_first ? ST_OK : head.status;
			last         <= send_first ? !head.has_status : 1'b1;
		end
	end

endmodule

### dv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Byte-stream check of the object datagram header parser.
	// A sender task feeds datagram bytes in bursts; a software parser works
	// out the header / payload / status results for each accepted request and
	// queues them; a monitor pops one expectation per accepted result and
	// compares it field by field. The receiver stalls on a mode pattern of
	// its own.

	import odhp_pkg::*;

	localparam int RANDOM_BYTES = 1800;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int TAIL_CYCLES  = 20;

	// parse phases of the software parser
	typedef enum logic [3:0] {
		P_TYPE, P_ALIAS, P_GROUP, P_OBJECT, P_PRIO,
		P_EXT_COUNT, P_EXT_KEY, P_EXT_LEN, P_EXT_VAL,
		P_PAYLOAD, P_DISCARD
	} phase_t;

	typedef struct {
		logic [1:0]      kind;
		logic [ID_W-1:0] alias_val;
		logic [ID_W-1:0] group_val;
		logic [ID_W-1:0] object_val;
		logic [7:0]      prio;
		logic [7:0]      pay;
		logic [1:0]      st;
		logic            last;
	} result_t;

	// directed row: byte, end flag, and a typed status where the row yields
	// only a status result that can be read off at a glance
	typedef struct packed {
		logic [7:0] data;
		logic       eod;
		logic       typed;
		logic [1:0] st;
	} dir_row_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_stall;
	logic [7:0]      data_byte = 8'h00;
	logic            end_of_datagram = 1'b0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	logic [1:0]      kind;
	logic [ID_W-1:0] alias_num;
	logic [ID_W-1:0] group_num;
	logic [ID_W-1:0] object_num;
	logic [7:0]      priority_res;
	logic [7:0]      payload_byte;
	logic [1:0]      status;
	logic            last;

	object_datagram_header_parser dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.data_byte       (data_byte),
		.end_of_datagram (end_of_datagram),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.kind            (kind),
		.alias_num       (alias_num),
		.group_num       (group_num),
		.object_num      (object_num),
		.priority_res    (priority_res),
		.payload_byte    (payload_byte),
		.status          (status),
		.last            (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Software parser state
	// ------------------------------------------------------------------
	phase_t          phase = P_TYPE;
	logic [ID_W-1:0] vint_acc = '0;
	int unsigned     vint_left = 0;
	logic            ext_flag = 1'b0;
	logic [ID_W-1:0] hold_alias = '0;
	logic [ID_W-1:0] hold_group = '0;
	logic [ID_W-1:0] hold_object = '0;
	logic [7:0]      hold_prio = '0;
	logic [ID_W-1:0] ext_remaining = '0;
	logic [ID_W-1:0] skip_remaining = '0;
	logic [1:0]      fail_code = ST_OK;

	result_t byte_results[$];  // results of the request just parsed
	result_t due_results[$];   // results still owed by the block
	result_t want;
	logic [7:0] dgram[$];      // datagram under construction
	bit ext_wanted;            // next datagram uses the extended type

	int mismatches = 0;
	int cycle_count = 0;
	int burst_left = 0;

	// One byte into the varint decoder; 1 when a value is complete.
	// Length prefix 0..3 means 0, 1, 3 or 7 more bytes.
	function automatic bit varint_take(logic [7:0] b);
		if (vint_left == 0) begin
			vint_acc = ID_W'(b[5:0] & VARINT_LOW_MASK);
			vint_left = (1 << b[7:6]) - 1;
		end else begin
			vint_acc = {vint_acc[ID_W-9:0], b};
			vint_left--;
		end
		return vint_left == 0;
	endfunction

	function automatic void queue_result(logic [1:0] k, logic [7:0] pb, logic [1:0] st);
		result_t r;
		r.kind = k;
		r.alias_val = (k == KIND_HEADER) ? hold_alias : '0;
		r.group_val = (k == KIND_HEADER) ? hold_group : '0;
		r.object_val = (k == KIND_HEADER) ? hold_object : '0;
		r.prio = (k == KIND_HEADER) ? hold_prio : '0;
		r.pay = (k == KIND_PAYLOAD) ? pb : '0;
		r.st = (k == KIND_STATUS) ? st : '0;
		r.last = 1'b0;
		byte_results = {byte_results, r};
	endfunction

	// one extension skipped: next key, or header out when the list is done
	function automatic void extension_finished();
		if (ext_remaining != 0)
			ext_remaining--;
		if (ext_remaining == 0) begin
			phase = P_PAYLOAD;
			queue_result(KIND_HEADER, '0, ST_OK);
		end else begin
			phase = P_EXT_KEY;
		end
	endfunction

	function automatic void clear_datagram();
		phase = P_TYPE;
		vint_acc = '0;
		vint_left = 0;
		ext_flag = 1'b0;
		ext_remaining = '0;
		skip_remaining = '0;
		fail_code = ST_OK;
	endfunction

	// Parse one accepted request; leaves its results in byte_results.
	function automatic void datagram_step(logic [7:0] b, logic eod);
		logic [1:0] st;
		byte_results.delete();
		case (phase)
			P_TYPE: begin
				if (varint_take(b)) begin
					if (vint_acc == TYPE_PLAIN || vint_acc == TYPE_EXTENDED) begin
						ext_flag = (vint_acc == TYPE_EXTENDED);
						phase = P_ALIAS;
					end else begin
						fail_code = ST_UNSUPPORTED;
						phase = P_DISCARD;
					end
				end
			end
			P_ALIAS: if (varint_take(b)) begin
				hold_alias = vint_acc;
				phase = P_GROUP;
			end
			P_GROUP: if (varint_take(b)) begin
				hold_group = vint_acc;
				phase = P_OBJECT;
			end
			P_OBJECT: if (varint_take(b)) begin
				hold_object = vint_acc;
				phase = P_PRIO;
			end
			P_PRIO: begin
				hold_prio = b;
				if (ext_flag) begin
					phase = P_EXT_COUNT;
				end else begin
					phase = P_PAYLOAD;
					queue_result(KIND_HEADER, '0, ST_OK);
				end
			end
			P_EXT_COUNT: if (varint_take(b)) begin
				ext_remaining = vint_acc;
				if (ext_remaining == 0) begin
					phase = P_PAYLOAD;
					queue_result(KIND_HEADER, '0, ST_OK);
				end else begin
					phase = P_EXT_KEY;
				end
			end
			P_EXT_KEY: if (varint_take(b))
				phase = P_EXT_LEN;
			P_EXT_LEN: if (varint_take(b)) begin
				skip_remaining = vint_acc;
				if (skip_remaining == 0)
					extension_finished();
				else
					phase = P_EXT_VAL;
			end
			P_EXT_VAL: begin
				if (skip_remaining != 0)
					skip_remaining--;
				if (skip_remaining == 0)
					extension_finished();
			end
			P_PAYLOAD: queue_result(KIND_PAYLOAD, b, ST_OK);
			default: phase = P_DISCARD;
		endcase

		if (eod) begin
			if (phase == P_PAYLOAD)
				st = ST_OK;
			else if (phase == P_DISCARD)
				st = (fail_code != ST_OK) ? fail_code : ST_UNSUPPORTED;
			else
				st = ST_TRUNCATED;
			queue_result(KIND_STATUS, '0, st);
			clear_datagram();
		end

		if (byte_results.size() > 0)
			byte_results[byte_results.size()-1].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Datagram construction for the random part
	// ------------------------------------------------------------------

	// random value spread over the 6/14/30/62-bit varint ranges, with the
	// range ends weighted up
	function automatic logic [ID_W-1:0] rand_field();
		logic [ID_W-1:0] mask;
		logic [ID_W-1:0] v;
		int sel;
		case ($urandom_range(0, 3))
			0: mask = {ID_W{1'b1}} >> (ID_W - 6);
			1: mask = {ID_W{1'b1}} >> (ID_W - 14);
			2: mask = {ID_W{1'b1}} >> (ID_W - 30);
			default: mask = {ID_W{1'b1}};
		endcase
		v = ID_W'({$urandom, $urandom}) & mask;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			v = '0;
		else if (sel == 1)
			v = mask;
		return v;
	endfunction

	// big-endian varint, sometimes in a longer form than needed
	function automatic void put_varint(logic [ID_W-1:0] v);
		int n;
		int k;
		n = (v < 64) ? 1 : (v < (1 << 14)) ? 2 : (v < (1 << 30)) ? 4 : 8;
		if ($urandom_range(0, 3) == 0)
			while (n < 8 && $urandom_range(0, 1) == 1)
				n = n * 2;
		dgram = {dgram, {2'($clog2(n)), 6'(v >> (8 * (n - 1)))}};
		for (k = n - 2; k >= 0; k--)
			dgram = {dgram, 8'(v >> (8 * k))};
	endfunction

	// Mostly well-formed datagrams with random content; some noise, some
	// unsupported types, some cut short anywhere (mid-varint included).
	function automatic void build_datagram();
		int pick;
		int n_ext;
		int n_val;
		int cut;
		logic [ID_W-1:0] cnt;
		logic [ID_W-1:0] len;
		logic [ID_W-1:0] t;
		dgram.delete();
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			repeat ($urandom_range(1, 12))
				dgram = {dgram, 8'($urandom)};
		end else if (pick < 15) begin
			t = rand_field();
			if (t < 2)
				t = ID_W'(2 + $urandom_range(0, 61));
			put_varint(t);
			repeat ($urandom_range(0, 6))
				dgram = {dgram, 8'($urandom)};
		end else begin
			put_varint(ext_wanted ? TYPE_EXTENDED : TYPE_PLAIN);
			put_varint(rand_field());
			put_varint(rand_field());
			put_varint(rand_field());
			dgram = {dgram, 8'($urandom)};
			// extension list when the type asked for one
			if (ext_wanted) begin
				cnt = ($urandom_range(0, 19) == 0) ? rand_field() : ID_W'($urandom_range(0, 3));
				put_varint(cnt);
				n_ext = (cnt > 4) ? $urandom_range(0, 2) : int'(cnt);
				repeat (n_ext) begin
					put_varint(rand_field());
					len = ($urandom_range(0, 19) == 0) ? rand_field() : ID_W'($urandom_range(0, 4));
					put_varint(len);
					n_val = (len > 6) ? $urandom_range(0, 6) : int'(len);
					repeat (n_val)
						dgram = {dgram, 8'($urandom)};
				end
			end
			repeat ($urandom_range(0, 8))
				dgram = {dgram, 8'($urandom)};
		end
		if ($urandom_range(0, 9) == 0) begin
			cut = $urandom_range(1, dgram.size());
			while (dgram.size() > cut)
				void'(dgram.pop_back());
		end
	endfunction

	// ------------------------------------------------------------------
	// Sender: one request per call, entered and left at a falling edge.
	// Bursts of random length, random gaps between them; now and then a
	// long burst with no idling at all.
	// ------------------------------------------------------------------
	task automatic send_byte(logic [7:0] b, logic eod, bit typed, logic [1:0] st);
		result_t r;
		if (burst_left == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 60);
		end
		burst_left--;
		in_valid = 1'b1;
		data_byte = b;
		end_of_datagram = eod;
		do
			@(posedge clk);
		while (in_stall);
		// request taken at this edge
		datagram_step(b, eod);
		if (typed) begin
			r.kind = KIND_STATUS;
			r.alias_val = '0;
			r.group_val = '0;
			r.object_val = '0;
			r.prio = '0;
			r.pay = '0;
			r.st = st;
			r.last = 1'b1;
			due_results = {due_results, r};
		end else begin
			due_results = {due_results, byte_results};
		end
		@(negedge clk);
	endtask

	// hold the sender off until the block owes nothing
	task automatic wait_idle();
		in_valid = 1'b0;
		while (due_results.size() != 0)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Receiver stall: a mode that changes every so often - never, light,
	// heavy, or a fixed repeating on/off pattern.
	// ------------------------------------------------------------------
	int stall_mode = 0;
	int mode_left = 50;
	int pat_pos = 0;

	always @(negedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(20, 200);
		end
		mode_left--;
		pat_pos = (pat_pos + 1) % 5;
		case (stall_mode)
			0: out_stall = 1'b0;
			1: out_stall = ($urandom_range(0, 9) < 3);
			2: out_stall = ($urandom_range(0, 9) < 7);
			default: out_stall = (pat_pos < 3);
		endcase
	end

	// ------------------------------------------------------------------
	// Monitor: every accepted result against the oldest expectation
	// ------------------------------------------------------------------
	function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, actual %0h", name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (due_results.size() == 0) begin
				$error("result with nothing expected: kind %0d", kind);
				mismatches++;
			end else begin
				want = due_results.pop_front();
				check_field("kind", 64'(want.kind), 64'(kind));
				check_field("alias_num", 64'(want.alias_val), 64'(alias_num));
				check_field("group_num", 64'(want.group_val), 64'(group_num));
				check_field("object_num", 64'(want.object_val), 64'(object_num));
				check_field("priority_res", 64'(want.prio), 64'(priority_res));
				check_field("payload_byte", 64'(want.pay), 64'(payload_byte));
				check_field("status", 64'(want.st), 64'(status));
				check_field("last", 64'(want.last), 64'(last));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Directed table
	//   truncated right after reset, extreme header values with a
	//   non-minimal type and an empty extension list, unsupported type with
	//   discarded bytes, header completed on the final byte
	// ------------------------------------------------------------------
	localparam int N_DIR = 26;
	dir_row_t dir_tab [N_DIR] = '{
		// type 0 alone, then end: early end
		'{8'h00, 1'b1, 1'b1, ST_TRUNCATED},
		// type 1 in two-byte form
		'{8'h40, 1'b0, 1'b0, ST_OK},
		'{8'h01, 1'b0, 1'b0, ST_OK},
		// alias 63, group 2^30-1, object 2^62-1
		'{8'h3F, 1'b0, 1'b0, ST_OK},
		'{8'hBF, 1'b0, 1'b0, ST_OK},
		'{8'hFF, 1'b0, 1'b0, ST_OK},
		'{8'hFF, 1'b0, 1'b0, ST_OK},
		'{8'hFF, 1'b0, 1'b0, ST_OK},
		'{8'hFF, 1'b0, 1'b0, ST_OK},
		'{8'hFF, 1'b0, 1'b0, ST_OK},
		'{8'hFF, 1'b0, 1'b0, ST_OK},
		'{8'hFF, 1'b0, 1'b0, ST_OK},
		'{8'hFF, 1'b0, 1'b0, ST_OK},
		'{8'hFF, 1'b0, 1'b0, ST_OK},
		'{8'hFF, 1'b0, 1'b0, ST_OK},
		'{8'hFF, 1'b0, 1'b0, ST_OK},
		// priority 0, extension count 0 -> header
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{8'h00, 1'b0, 1'b0, ST_OK},
		// payload on the final byte
		'{8'hFF, 1'b1, 1'b0, ST_OK},
		// type 2: rest discarded
		'{8'h02, 1'b0, 1'b0, ST_OK},
		'{8'h55, 1'b1, 1'b1, ST_UNSUPPORTED},
		// type 0, all ids zero, priority on the final byte
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{8'h00, 1'b0, 1'b0, ST_OK},
		'{8'h80, 1'b1, 1'b0, ST_OK}
	};

	int sent = 0;
	bit drained_mid = 1'b0;

	initial begin
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < N_DIR; i++)
			send_byte(dir_tab[i].data, dir_tab[i].eod, dir_tab[i].typed, dir_tab[i].st);
		wait_idle();

		while (sent < RANDOM_BYTES) begin
			ext_wanted = ($urandom_range(0, 1) == 1);
			build_datagram();
			foreach (dgram[i])
				send_byte(dgram[i], i == dgram.size() - 1, 1'b0, ST_OK);
			sent += dgram.size();
			// one full drain halfway through
			if (!drained_mid && sent >= RANDOM_BYTES / 2) begin
				wait_idle();
				drained_mid = 1'b1;
			end
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0 && due_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
